FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, switched off while reset is low.
`define ASSERT_CLKD(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/mm3_pkg.sv
package mm3_pkg;

  // Matrix size and derived counts
  localparam int DIM     = 3;
  localparam int CELLS   = DIM * DIM;
  localparam int LOADS   = 2 * CELLS;
  localparam int CELL_AW = $clog2(CELLS);
  localparam int CNT_W   = $clog2(LOADS);
  localparam int IDX_W   = $clog2(DIM);

  // Field widths
  localparam int ELEM_W  = 16;
  localparam int MUL_W   = 2 * ELEM_W;
  localparam int ACC_W   = MUL_W + $clog2(DIM);
  localparam int PROD_W  = 33;
  localparam int RC_W    = 2;

  // Stream data widths, padded to whole bytes
  localparam int IN_DATA_W  = ((ELEM_W + 7) / 8) * 8;
  localparam int OUT_FLD_W  = PROD_W + 2 * RC_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FLD_W;

  // Bit positions of the output fields in tdata
  localparam int ROW_LSB = PROD_W;
  localparam int COL_LSB = PROD_W + RC_W;

  // Tag carried alongside each multiply-accumulate
  typedef struct packed {
    logic             first;
    logic             last;
    logic             fin;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mac_tag_t;

endpackage

FILE: src/mm3_ram.sv
module mm3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 9
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/matrix_multiply_3x3_unit.sv
// Channel   Dir  Fields (tdata from bit 0 up)                     Notes
// s_axis    in   element_value[15:0]                              A then B, row-major
// m_axis    out  product_value[32:0], row_index[34:33],           tlast = last_entry
//                col_index[36:35], zeros[39:37]
//
// Loading takes one cycle per item; s_axis_tready is high only while loading.
// After the final B element, one shared MAC reads A and B from two RAMs whose
// reads are registered. Each product entry goes through DIM reads, the RAM read
// register, the product register, accumulation into the output, and the drain state.
// A finished entry waits in the output register; the next entry starts only once
// that register is free. Reset clears the load count and control; RAMs are kept.
module matrix_multiply_3x3_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [mm3_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // element_value
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [mm3_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // product_value, row, col, pad
  output logic                             m_axis_tlast   // last_entry
);

  typedef enum logic [1:0] {ST_LOAD, ST_ISSUE, ST_DRAIN} state_e;

  state_e                        state_q;
  logic [mm3_pkg::CNT_W-1:0]     cnt_q;
  logic [mm3_pkg::IDX_W-1:0]     r_q, c_q, k_q;
  logic                          all_iss_q;
  logic                          v1_q, v2_q;
  logic                          m_valid_q;

  mm3_pkg::mac_tag_t             tag_d, tag1_q, tag2_q;
  logic signed [mm3_pkg::ELEM_W-1:0] a_rdata, b_rdata;
  logic signed [mm3_pkg::MUL_W-1:0]  prod_q;
  logic signed [mm3_pkg::ACC_W-1:0]  acc_q, acc_base, acc_sum;
  logic [mm3_pkg::PROD_W-1:0]    m_prod_q;
  logic [mm3_pkg::RC_W-1:0]      m_row_q, m_col_q;
  logic                          m_last_q;

  logic                          s_acc, issue, out_free, wb;
  logic                          we_a, we_b;
  logic [mm3_pkg::CELL_AW-1:0]   a_waddr, b_waddr, a_raddr, b_raddr;

  // Handshake and control decode
  assign s_axis_tready = (state_q == ST_LOAD);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign issue         = (state_q == ST_ISSUE);
  assign out_free      = !m_valid_q || m_axis_tready;
  assign wb            = v2_q && tag2_q.last;

  // Load addressing: A first, then B
  assign we_a    = s_acc && (cnt_q < mm3_pkg::CNT_W'(mm3_pkg::CELLS));
  assign we_b    = s_acc && !(cnt_q < mm3_pkg::CNT_W'(mm3_pkg::CELLS));
  assign a_waddr = mm3_pkg::CELL_AW'(cnt_q);
  assign b_waddr = mm3_pkg::CELL_AW'(cnt_q - mm3_pkg::CNT_W'(mm3_pkg::CELLS));

  // Read addressing: A[r][k] and B[k][c]
  assign a_raddr = mm3_pkg::CELL_AW'(r_q * mm3_pkg::DIM + k_q);
  assign b_raddr = mm3_pkg::CELL_AW'(k_q * mm3_pkg::DIM + c_q);

  always_comb begin
    tag_d.first = (k_q == '0);
    tag_d.last  = (k_q == mm3_pkg::IDX_W'(mm3_pkg::DIM - 1));
    tag_d.fin   = (r_q == mm3_pkg::IDX_W'(mm3_pkg::DIM - 1)) &&
                  (c_q == mm3_pkg::IDX_W'(mm3_pkg::DIM - 1));
    tag_d.row   = r_q;
    tag_d.col   = c_q;
  end

  mm3_ram #(.WIDTH(mm3_pkg::ELEM_W), .DEPTH(mm3_pkg::CELLS)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (a_waddr),
    .wdata_i (s_axis_tdata[mm3_pkg::ELEM_W-1:0]),
    .re_i    (issue),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mm3_ram #(.WIDTH(mm3_pkg::ELEM_W), .DEPTH(mm3_pkg::CELLS)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (b_waddr),
    .wdata_i (s_axis_tdata[mm3_pkg::ELEM_W-1:0]),
    .re_i    (issue),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // Accumulate: restart on the first term of each entry
  assign acc_base = tag2_q.first ? '0 : acc_q;
  assign acc_sum  = acc_base + mm3_pkg::ACC_W'(prod_q);

  // State, counters, pipeline valids and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      cnt_q     <= '0;
      r_q       <= '0;
      c_q       <= '0;
      k_q       <= '0;
      all_iss_q <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (wb) begin
        m_valid_q <= 1'b1;
      end
      unique case (state_q)
        ST_LOAD: begin
          if (s_acc) begin
            if (cnt_q == mm3_pkg::CNT_W'(mm3_pkg::LOADS - 1)) begin
              cnt_q     <= '0;
              all_iss_q <= 1'b0;
              state_q   <= ST_DRAIN;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        ST_ISSUE: begin
          if (k_q == mm3_pkg::IDX_W'(mm3_pkg::DIM - 1)) begin
            k_q     <= '0;
            state_q <= ST_DRAIN;
            if (c_q == mm3_pkg::IDX_W'(mm3_pkg::DIM - 1)) begin
              c_q <= '0;
              if (r_q == mm3_pkg::IDX_W'(mm3_pkg::DIM - 1)) begin
                r_q       <= '0;
                all_iss_q <= 1'b1;
              end else begin
                r_q <= r_q + 1'b1;
              end
            end else begin
              c_q <= c_q + 1'b1;
            end
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          // wait for the pipeline to empty; before another issue, also for the output register to free up
          if (!v1_q && !v2_q) begin
            if (all_iss_q) begin
              state_q <= ST_LOAD;
            end else if (out_free) begin
              state_q <= ST_ISSUE;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  // Datapath: tags, multiply, accumulate, output payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      tag1_q <= tag_d;
    end
    tag2_q <= tag1_q;
    prod_q <= a_rdata * b_rdata;
    if (v2_q) begin
      acc_q <= acc_sum;
    end
    if (wb) begin
      m_prod_q <= mm3_pkg::PROD_W'(acc_sum);
      m_row_q  <= mm3_pkg::RC_W'(tag2_q.row);
      m_col_q  <= mm3_pkg::RC_W'(tag2_q.col);
      m_last_q <= tag2_q.fin;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{mm3_pkg::OUT_PAD_W{1'b0}}, m_col_q, m_row_q, m_prod_q};
  assign m_axis_tlast  = m_last_q;

endmodule

FILE: src/mm3_checker.sv
`include "assert_macros.svh"

module mm3_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tready,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [mm3_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           m_axis_tlast
);

  logic [mm3_pkg::RC_W-1:0] row, col;
  logic                     corner;
  logic                     out_stall, mid_take;
  logic [mm3_pkg::OUT_DATA_W:0] out_word;

  assign row       = m_axis_tdata[mm3_pkg::ROW_LSB +: mm3_pkg::RC_W];
  assign col       = m_axis_tdata[mm3_pkg::COL_LSB +: mm3_pkg::RC_W];
  assign corner    = (row == mm3_pkg::RC_W'(mm3_pkg::DIM - 1)) &&
                     (col == mm3_pkg::RC_W'(mm3_pkg::DIM - 1));
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign mid_take  = m_axis_tvalid && m_axis_tready && !m_axis_tlast;
  assign out_word  = {m_axis_tlast, m_axis_tdata};

  // A stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(out_word))

  // The final entry, and only that one, carries tlast
  `ASSERT_CLKD(a_last_corner, clk_i, rst_ni, !m_axis_tvalid || (m_axis_tlast == corner))

  // Indices stay inside the matrix
  `ASSERT_CLKD(a_idx_range, clk_i, rst_ni, !m_axis_tvalid || (row != 2'd3 && col != 2'd3))

  // No loading while entries of a product are still being delivered
  `ASSERT_CLKD(a_no_load_mid, clk_i, rst_ni, !mid_take || !s_axis_tready)

endmodule

bind matrix_multiply_3x3_unit mm3_checker u_mm3_checker (.*);
